// File: design/sfsct_pkg.sv
package sfsct_pkg;

  localparam int SLOTS_DEF      = 4;
  localparam int CHILD_BITS_DEF = 48;
  localparam int MODE_W         = 3;
  localparam int KEY_W          = 8;
  localparam int STATUS_W       = 3;

  typedef enum logic [MODE_W-1:0] {
    MODE_LOOKUP = 3'd0,
    MODE_INSERT = 3'd1,
    MODE_CHANGE = 3'd2,
    MODE_REMOVE = 3'd3,
    MODE_RANGE  = 3'd4
  } mode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_NOT_FOUND = 3'd1,
    ST_FULL      = 3'd2,
    ST_PRESENT   = 3'd3,
    ST_EMPTY     = 3'd4
  } status_e;

  // controller to datapath
  typedef struct packed {
    logic load;  // capture the incoming item
    logic exec;  // run the operation, update slots and result
  } cmd_t;

endpackage

// File: design/sfsct_ctrl.sv
module sfsct_ctrl
  import sfsct_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  output cmd_t cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_DONE = 3'b100
  } state_e;

  state_e state_q, state_d;

  // take the next item in the same cycle the result leaves
  assign in_ready_o  = (state_q == S_IDLE) || ((state_q == S_DONE) && out_ready_i);
  assign out_valid_o = (state_q == S_DONE);
  assign cmd_o.load  = in_valid_i && in_ready_o;
  assign cmd_o.exec  = (state_q == S_EXEC);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_EXEC;
      end
      S_EXEC: begin
        state_d = S_DONE;
      end
      S_DONE: begin
        if (out_ready_i) state_d = in_valid_i ? S_EXEC : S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: design/sfsct_datapath.sv
module sfsct_datapath
  import sfsct_pkg::*;
#(
  parameter int SLOTS      = SLOTS_DEF,
  parameter int CHILD_BITS = CHILD_BITS_DEF,
  parameter int EW         = $clog2(SLOTS + 1)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cmd_t                  cmd_i,
  input  logic [MODE_W-1:0]     mode_i,
  input  logic [KEY_W-1:0]      key_i,
  input  logic [CHILD_BITS-1:0] child_i,
  output logic [STATUS_W-1:0]   status_o,
  output logic [CHILD_BITS-1:0] child_out_o,
  output logic                  has_smaller_o,
  output logic                  has_bigger_o,
  output logic [EW-1:0]         entries_o
);

  logic [MODE_W-1:0]     mode_q;
  logic [KEY_W-1:0]      key_q;
  logic [CHILD_BITS-1:0] child_q;

  logic [KEY_W-1:0]      keys_q [SLOTS];
  logic [KEY_W-1:0]      keys_d [SLOTS];
  logic [CHILD_BITS-1:0] kids_q [SLOTS];
  logic [CHILD_BITS-1:0] kids_d [SLOTS];
  logic [EW-1:0]         fill_q, fill_d;

  logic [STATUS_W-1:0]   status_q, status_d;
  logic [CHILD_BITS-1:0] cout_q, cout_d;
  logic                  smaller_q, smaller_d;
  logic                  bigger_q, bigger_d;

  logic [SLOTS-1:0]      valid, eq, lt, ge, sel;
  logic                  hit;
  logic [CHILD_BITS-1:0] hit_child, range_child;
  logic [SLOTS-1:0]      gone;

  // per-slot compares against the held key
  always_comb begin
    for (int j = 0; j < SLOTS; j++) begin
      valid[j] = (EW'(j) < fill_q);
      eq[j]    = valid[j] && (keys_q[j] == key_q);
      lt[j]    = valid[j] && (keys_q[j] < key_q);
      ge[j]    = valid[j] && (keys_q[j] >= key_q);
    end
  end

  // keys are sorted and distinct, so eq is at most one-hot and ge is a suffix
  always_comb begin
    logic run;
    run       = 1'b0;
    hit       = |eq;
    hit_child = '0;
    for (int j = 0; j < SLOTS; j++) begin
      if (eq[j]) hit_child = hit_child | kids_q[j];
      run     = run | eq[j];
      gone[j] = run;
    end
    sel[0] = ge[1];
    for (int j = 1; j < SLOTS - 1; j++) begin
      sel[j] = ge[j+1] && !ge[j];
    end
    sel[SLOTS-1] = 1'b0;
    // single entry: child of slot 0
    if (fill_q == EW'(1)) sel[0] = 1'b1;
    range_child = '0;
    for (int j = 0; j < SLOTS; j++) begin
      if (sel[j]) range_child = range_child | kids_q[j];
    end
  end

  always_comb begin
    keys_d    = keys_q;
    kids_d    = kids_q;
    fill_d    = fill_q;
    status_d  = ST_OK;
    cout_d    = '0;
    smaller_d = 1'b0;
    bigger_d  = 1'b0;
    unique case (mode_e'(mode_q))
      MODE_LOOKUP: begin
        if (hit) cout_d = hit_child;
        else     status_d = ST_NOT_FOUND;
      end
      MODE_INSERT: begin
        if (fill_q >= EW'(SLOTS)) begin
          status_d = ST_FULL;
        end else if (hit) begin
          status_d = ST_PRESENT;
        end else begin
          // slots below the key stay, the first slot not below takes the new entry,
          // later ones shift up
          if (!lt[0]) begin
            keys_d[0] = key_q;
            kids_d[0] = child_q;
          end
          for (int j = 1; j < SLOTS; j++) begin
            if (!lt[j]) begin
              if (lt[j-1]) begin
                keys_d[j] = key_q;
                kids_d[j] = child_q;
              end else begin
                keys_d[j] = keys_q[j-1];
                kids_d[j] = kids_q[j-1];
              end
            end
          end
          fill_d = fill_q + EW'(1);
        end
      end
      MODE_CHANGE: begin
        if (!hit) status_d = ST_NOT_FOUND;
        for (int j = 0; j < SLOTS; j++) begin
          if (eq[j]) kids_d[j] = child_q;
        end
      end
      MODE_REMOVE: begin
        if (!hit) begin
          status_d = ST_NOT_FOUND;
        end else begin
          // close the gap from the removed slot upward
          for (int j = 0; j < SLOTS - 1; j++) begin
            if (gone[j]) begin
              keys_d[j] = keys_q[j+1];
              kids_d[j] = kids_q[j+1];
            end
          end
          fill_d = fill_q - EW'(1);
        end
      end
      MODE_RANGE: begin
        if (fill_q == '0) begin
          status_d = ST_EMPTY;
        end else if (!lt[0] && !eq[0]) begin
          bigger_d = 1'b1;
        end else if (ge == '0) begin
          smaller_d = 1'b1;
        end else begin
          smaller_d = 1'b1;
          bigger_d  = 1'b1;
          cout_d    = range_child;
        end
      end
      default: begin
        status_d = ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q  <= mode_i;
      key_q   <= key_i;
      child_q <= child_i;
    end
    if (cmd_i.exec) begin
      keys_q    <= keys_d;
      kids_q    <= kids_d;
      status_q  <= status_d;
      cout_q    <= cout_d;
      smaller_q <= smaller_d;
      bigger_q  <= bigger_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else if (cmd_i.exec) begin
      fill_q <= fill_d;
    end
  end

  assign status_o      = status_q;
  assign child_out_o   = cout_q;
  assign has_smaller_o = smaller_q;
  assign has_bigger_o  = bigger_q;
  // fill only moves on exec, which follows the input accept
  assign entries_o     = fill_q;

endmodule

// File: design/sorted_four_slot_child_table_top.sv
// After an input is accepted, the controller passes through its execute state and then
// presents the registered result on m_axis_tvalid_o.
// No new item is taken while one is in flight; a new item is taken in the same cycle
// the previous result is handed off.
// Reset: asynchronous, active low; clears the controller and the entry count.
// Slot keys and children are not cleared; only slots below the count are read.
module sorted_four_slot_child_table_top
  import sfsct_pkg::*;
#(
  parameter int SLOTS      = SLOTS_DEF,
  parameter int CHILD_BITS = CHILD_BITS_DEF,
  localparam int EW        = $clog2(SLOTS + 1),
  localparam int IN_BITS   = MODE_W + KEY_W + CHILD_BITS,
  localparam int IN_W      = ((IN_BITS + 7) / 8) * 8,
  localparam int OUT_BITS  = STATUS_W + CHILD_BITS + 2 + EW,
  localparam int OUT_W     = ((OUT_BITS + 7) / 8) * 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // mode, key, child
  input  logic [IN_W-1:0]  s_axis_tdata_i,
  output logic             m_axis_tvalid_o,
  input  logic             m_axis_tready_i,
  // status, child_out, has_smaller, has_bigger, entries
  output logic [OUT_W-1:0] m_axis_tdata_o
);

  cmd_t                  cmd;
  logic [STATUS_W-1:0]   status;
  logic [CHILD_BITS-1:0] child_out;
  logic                  has_smaller, has_bigger;
  logic [EW-1:0]         entries;

  sfsct_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .cmd_o       (cmd)
  );

  sfsct_datapath #(
    .SLOTS      (SLOTS),
    .CHILD_BITS (CHILD_BITS),
    .EW         (EW)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .mode_i        (s_axis_tdata_i[MODE_W-1:0]),
    .key_i         (s_axis_tdata_i[MODE_W +: KEY_W]),
    .child_i       (s_axis_tdata_i[MODE_W+KEY_W +: CHILD_BITS]),
    .status_o      (status),
    .child_out_o   (child_out),
    .has_smaller_o (has_smaller),
    .has_bigger_o  (has_bigger),
    .entries_o     (entries)
  );

  always_comb begin
    m_axis_tdata_o = '0;
    m_axis_tdata_o[STATUS_W-1:0]                = status;
    m_axis_tdata_o[STATUS_W +: CHILD_BITS]      = child_out;
    m_axis_tdata_o[STATUS_W+CHILD_BITS]         = has_smaller;
    m_axis_tdata_o[STATUS_W+CHILD_BITS+1]       = has_bigger;
    m_axis_tdata_o[STATUS_W+CHILD_BITS+2 +: EW] = entries;
  end

`ifndef SYNTHESIS
  a_entries_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (entries <= EW'(SLOTS)))
    else $error("entry count above slot count");

  a_exec_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> !m_axis_tvalid_o)
    else $error("result shown in the execute cycle");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && (status == ST_FULL)) |-> (entries == EW'(SLOTS)))
    else $error("full reported below slot count");

  a_flags_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && (has_smaller || has_bigger)) |-> (status == ST_OK))
    else $error("range flags with error status");
`endif

endmodule

// File: test/tb.sv
`timescale 1ns / 1ps

module tb;
  import sfsct_pkg::*;

  localparam int SLOTS     = SLOTS_DEF;
  localparam int CB        = CHILD_BITS_DEF;
  localparam int EW        = $clog2(SLOTS + 1);
  localparam int IN_BITS   = MODE_W + KEY_W + CB;
  localparam int IN_W      = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS  = STATUS_W + CB + 2 + EW;
  localparam int OUT_W     = ((OUT_BITS + 7) / 8) * 8;
  localparam int N_RANDOM  = 1250;
  localparam int MAX_CYCLES = 400000;
  localparam logic [MODE_W-1:0] MODE_SPARE_MIN = 3'd5;
  localparam logic [MODE_W-1:0] MODE_SPARE_MAX = 3'd7;

  typedef struct packed {
    logic [CB-1:0]     child;
    logic [KEY_W-1:0]  key;
    logic [MODE_W-1:0] mode;
  } request_t;

  typedef struct packed {
    logic [EW-1:0]       entries;
    logic                bigger;
    logic                smaller;
    logic [CB-1:0]       child;
    logic [STATUS_W-1:0] status;
  } answer_t;

  typedef struct {
    request_t req;
    bit       drain;
    int       phase;
  } pending_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [IN_W-1:0]  s_tdata = '0;
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;

  sorted_four_slot_child_table_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata)
  );

  always #6 clk_i = ~clk_i;

  // shadow copy of the table
  logic [KEY_W-1:0] tbl_key [SLOTS];
  logic [CB-1:0]    tbl_kid [SLOTS];
  int               tbl_fill = 0;

  pending_t stim_q[$];
  answer_t  answer_q[$];
  request_t cur_req;
  int       cur_phase = 0;
  int       n_accepted = 0;
  int       n_results = 0;
  int       n_errors = 0;
  int       cycles = 0;
  int       mode_seen [8];
  int       status_seen [8];

  function automatic answer_t table_op(request_t r);
    answer_t res;
    int hit;
    int i;
    res = '0;
    hit = -1;
    for (i = 0; i < tbl_fill; i++)
      if (tbl_key[i] == r.key) hit = i;
    case (r.mode)
      MODE_LOOKUP: begin
        if (hit < 0) res.status = ST_NOT_FOUND;
        else res.child = tbl_kid[hit];
      end
      MODE_INSERT: begin
        if (tbl_fill >= SLOTS) begin
          res.status = ST_FULL;
        end else if (hit >= 0) begin
          res.status = ST_PRESENT;
        end else begin
          i = tbl_fill;
          while (i > 0 && tbl_key[i-1] > r.key) begin
            tbl_key[i] = tbl_key[i-1];
            tbl_kid[i] = tbl_kid[i-1];
            i--;
          end
          tbl_key[i] = r.key;
          tbl_kid[i] = r.child;
          tbl_fill++;
        end
      end
      MODE_CHANGE: begin
        if (hit < 0) res.status = ST_NOT_FOUND;
        else tbl_kid[hit] = r.child;
      end
      MODE_REMOVE: begin
        if (hit < 0) begin
          res.status = ST_NOT_FOUND;
        end else begin
          for (i = hit; i < tbl_fill - 1; i++) begin
            tbl_key[i] = tbl_key[i+1];
            tbl_kid[i] = tbl_kid[i+1];
          end
          tbl_fill--;
        end
      end
      MODE_RANGE: begin
        if (tbl_fill == 0) begin
          res.status = ST_EMPTY;
        end else if (tbl_key[0] > r.key) begin
          res.bigger = 1'b1;
        end else if (tbl_key[tbl_fill-1] < r.key) begin
          res.smaller = 1'b1;
        end else begin
          res.smaller = 1'b1;
          res.bigger  = 1'b1;
          res.child   = tbl_kid[tbl_fill-1];
          // walk down so the slot just below the lowest slot at or above the key wins
          for (i = tbl_fill - 1; i >= 1; i--)
            if (tbl_key[i] >= r.key) res.child = tbl_kid[i-1];
        end
      end
      default: ;
    endcase
    res.entries = EW'(tbl_fill);
    return res;
  endfunction

  function automatic int idle_pct(int phase, bit rx);
    case (phase)
      0: return rx ? 62 : 15;
      1: return rx ? 15 : 62;
      default: return 0;
    endcase
  endfunction

  function automatic logic [CB-1:0] rand_child();
    int r;
    r = $urandom_range(15);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return CB'({$urandom, $urandom});
  endfunction

  task automatic add_req(logic [MODE_W-1:0] mode, logic [KEY_W-1:0] key,
                         logic [CB-1:0] child, bit drain, int phase);
    pending_t p;
    p.req.mode  = mode;
    p.req.key   = key;
    p.req.child = child;
    p.drain     = drain;
    p.phase     = phase;
    stim_q.push_back(p);
  endtask

  // driver
  always @(posedge clk_i or negedge rst_ni) begin : drv
    pending_t nxt;
    logic     stalled;
    if (!rst_ni) begin
      s_tvalid <= 1'b0;
      s_tdata  <= '0;
    end else begin
      stalled = s_tvalid && !s_tready;
      if (s_tvalid && s_tready) begin
        answer_q.push_back(table_op(cur_req));
        mode_seen[cur_req.mode]++;
        n_accepted++;
      end
      if (!stalled) begin
        if (stim_q.size() > 0 && !(stim_q[0].drain && answer_q.size() > 0) &&
            $urandom_range(99) >= idle_pct(stim_q[0].phase, 1'b0)) begin
          nxt       = stim_q.pop_front();
          cur_req   = nxt.req;
          cur_phase = nxt.phase;
          s_tvalid <= 1'b1;
          s_tdata  <= IN_W'(nxt.req);
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin : mon
    answer_t got;
    answer_t want;
    if (!rst_ni) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = answer_t'(m_tdata[OUT_BITS-1:0]);
        n_results++;
        if (answer_q.size() == 0) begin
          n_errors++;
          if (n_errors <= 10)
            $display("unexpected result: status %0d child %h lt %b gt %b n %0d",
                     got.status, got.child, got.smaller, got.bigger, got.entries);
        end else begin
          want = answer_q.pop_front();
          status_seen[want.status]++;
          if (got.status !== want.status || got.child !== want.child ||
              got.smaller !== want.smaller || got.bigger !== want.bigger ||
              got.entries !== want.entries) begin
            n_errors++;
            if (n_errors <= 10) begin
              $write("mismatch at result %0d: expected status %0d child %h lt %b gt %b n %0d,",
                     n_results, want.status, want.child, want.smaller, want.bigger,
                     want.entries);
              $display(" got status %0d child %h lt %b gt %b n %0d",
                       got.status, got.child, got.smaller, got.bigger, got.entries);
            end
          end
        end
      end
      m_tready <= ($urandom_range(99) >= idle_pct(cur_phase, 1'b1));
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > MAX_CYCLES) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, answer_q.size());
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin : stim
    logic [KEY_W-1:0]  pool [6];
    logic [MODE_W-1:0] mode;
    logic [KEY_W-1:0]  key;
    int real_ops;
    int n;
    int pick;
    int phase;
    int last_phase;
    int m;

    for (m = 0; m < 8; m++) begin
      mode_seen[m]   = 0;
      status_seen[m] = 0;
    end

    // directed: empty table, fill to full, edges of range check, spare modes
    add_req(MODE_RANGE,  8'h55, '0, 1'b0, 0);
    add_req(MODE_LOOKUP, 8'h55, '0, 1'b0, 0);
    add_req(MODE_CHANGE, 8'h55, '1, 1'b0, 0);
    add_req(MODE_REMOVE, 8'h55, '0, 1'b0, 0);
    add_req(MODE_INSERT, 8'h80, '1, 1'b0, 0);
    add_req(MODE_RANGE,  8'h80, '0, 1'b0, 0);
    add_req(MODE_INSERT, 8'h00, CB'(1), 1'b0, 0);
    add_req(MODE_INSERT, 8'hFF, CB'(48'h5A5A_A5A5_0F0F), 1'b0, 0);
    add_req(MODE_INSERT, 8'h80, '0, 1'b0, 0);
    add_req(MODE_INSERT, 8'h40, CB'(48'hA5A5_5A5A_F0F0), 1'b0, 0);
    add_req(MODE_INSERT, 8'h10, CB'(2), 1'b0, 0);
    add_req(MODE_INSERT, 8'h80, CB'(3), 1'b0, 0);
    add_req(MODE_LOOKUP, 8'hFF, '0, 1'b0, 0);
    add_req(MODE_LOOKUP, 8'h41, '0, 1'b0, 0);
    add_req(MODE_CHANGE, 8'h40, '0, 1'b0, 0);
    add_req(MODE_CHANGE, 8'h41, '1, 1'b0, 0);
    add_req(MODE_RANGE,  8'h80, '0, 1'b0, 0);
    add_req(MODE_RANGE,  8'h7F, '0, 1'b0, 0);
    add_req(MODE_RANGE,  8'h00, '0, 1'b0, 0);
    add_req(MODE_REMOVE, 8'h00, '0, 1'b0, 0);
    add_req(MODE_REMOVE, 8'hFF, '0, 1'b0, 0);
    add_req(MODE_RANGE,  8'h00, '0, 1'b0, 0);
    add_req(MODE_RANGE,  8'hFF, '0, 1'b0, 0);
    for (m = MODE_SPARE_MIN; m <= MODE_SPARE_MAX; m++)
      add_req(MODE_W'(m), KEY_W'($urandom), CB'({$urandom, $urandom}), 1'b0, 0);

    // random: keys mostly from a small rotating pool so hits stay common
    real_ops   = 0;
    n          = 0;
    last_phase = 0;
    while (real_ops < N_RANDOM) begin
      if (n % 48 == 0)
        for (m = 0; m < 6; m++) pool[m] = KEY_W'($urandom);
      pick = $urandom_range(99);
      if (pick < 20) mode = MODE_LOOKUP;
      else if (pick < 45) mode = MODE_INSERT;
      else if (pick < 60) mode = MODE_CHANGE;
      else if (pick < 80) mode = MODE_REMOVE;
      else if (pick < 95) mode = MODE_RANGE;
      else mode = MODE_W'($urandom_range(MODE_SPARE_MIN, MODE_SPARE_MAX));
      pick = $urandom_range(9);
      if (pick < 7) key = pool[$urandom_range(5)];
      else if (pick == 7) key = KEY_W'($urandom);
      else key = $urandom_range(1) ? '1 : '0;
      // nudge range probes next to stored keys
      if (mode == MODE_RANGE && $urandom_range(1))
        key = key + KEY_W'($urandom_range(2)) - KEY_W'(1);
      phase = (real_ops < N_RANDOM / 3) ? 0 : (real_ops < 2 * N_RANDOM / 3) ? 1 : 2;
      add_req(mode, key, rand_child(),
              (phase != last_phase) || (real_ops == 1000 && mode <= MODE_RANGE), phase);
      last_phase = phase;
      if (mode <= MODE_RANGE) real_ops++;
      n++;
    end

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (stim_q.size() > 0 || s_tvalid) @(posedge clk_i);
    while (answer_q.size() > 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("%0d requests: lookup %0d, insert %0d, change %0d, remove %0d, range %0d, spare %0d",
             n_accepted, mode_seen[MODE_LOOKUP], mode_seen[MODE_INSERT],
             mode_seen[MODE_CHANGE], mode_seen[MODE_REMOVE], mode_seen[MODE_RANGE],
             n_accepted - mode_seen[MODE_LOOKUP] - mode_seen[MODE_INSERT] -
             mode_seen[MODE_CHANGE] - mode_seen[MODE_REMOVE] - mode_seen[MODE_RANGE]);
    $display("statuses: ok %0d, miss %0d, full %0d, present %0d, empty %0d; %0d mismatches",
             status_seen[ST_OK], status_seen[ST_NOT_FOUND], status_seen[ST_FULL],
             status_seen[ST_PRESENT], status_seen[ST_EMPTY], n_errors);
    if (n_errors == 0 && answer_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
